// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the block.
// All checks run on the rising edge of clk and are off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/amsco_pkg.sv
// ----------------------------------------------------------------------------
// Amsco decrypt package
// Shared constants, types and the chunk dealing step.
// ----------------------------------------------------------------------------
package amsco_pkg;

  localparam int MAX_TEXT    = 64;
  localparam int MAX_COLUMNS = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int TEXT_AW  = $clog2(MAX_TEXT);
  localparam int COUNT_W  = $clog2(MAX_TEXT + 1);
  localparam int COL_W    = $clog2(MAX_COLUMNS);
  localparam int KEY_W    = 5;
  localparam int ORDER_W  = 64;
  localparam int ENTRY_W  = 4;
  localparam int BASE_W   = $clog2(MAX_COLUMNS * MAX_TEXT + MAX_TEXT + 1);
  localparam int QAW      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CHUNK_ONE = 2'd1;
  localparam logic [1:0] CHUNK_TWO = 2'd2;

  localparam logic [1:0] REG_KEY_LENGTH    = 2'd0;
  localparam logic [1:0] REG_COLUMN_ORDER  = 2'd1;
  localparam logic [1:0] REG_START_SIZE    = 2'd2;
  localparam logic [1:0] REG_SWAP_VERTICAL = 2'd3;

  typedef enum logic [2:0] {
    B_LOAD,
    B_SIZE,
    B_BASE,
    B_ADDR,
    B_DATA
  } back_state_t;

  typedef struct packed {
    logic [7:0]         data;
    logic [TEXT_AW-1:0] addr;
    logic               store;
    logic               last;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } queue_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_length;
    logic [ORDER_W-1:0] column_order;
    logic [1:0]         start_size;
    logic               swap_vertical;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       chunk;
    logic [COL_W-1:0] col;
  } deal_t;

  function automatic logic [1:0] toggle_chunk(input logic [1:0] chunk);
    return (chunk == CHUNK_TWO) ? CHUNK_ONE : CHUNK_TWO;
  endfunction

  // One dealing step: flip the chunk size and move to the next column.
  function automatic deal_t deal_advance(input logic [1:0] chunk,
                                         input logic [COL_W-1:0] col,
                                         input logic [KEY_W-1:0] k,
                                         input logic swap);
    deal_t            r;
    logic [KEY_W-1:0] nxt;
    r.chunk = toggle_chunk(chunk);
    nxt = KEY_W'(col) + KEY_W'(1);
    if (nxt >= k) begin
      nxt = '0;
    end
    r.col = nxt[COL_W-1:0];
    if ((nxt == '0) && swap && !k[0]) begin
      r.chunk = toggle_chunk(r.chunk);
    end
    return r;
  endfunction

endpackage

// File: rtl/amsco_transposition_decrypt_top.sv
// ----------------------------------------------------------------------------
// Amsco transposition decrypt top level
// Configuration registers, front end, word queue and decrypt engine.
// ----------------------------------------------------------------------------
// Words load as the queue drains; the engine pops them only while loading.
// After the last word it sizes the columns chunk by chunk, places them in key
// order, then reads each plaintext word through the buffer read port and
// output register. Reset clears all control state and the registers to their
// defaults; buffer contents are undefined until written.
module amsco_transposition_decrypt_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] cipher_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] plain_byte
  output logic        m_tlast,
  output logic        m_tuser    // [0] overflow
);
  import amsco_pkg::*;

  cfg_t        cfg;
  logic        cfg_write;
  logic [1:0]  reg_sel;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  queue_word_t q_in;
  queue_word_t q_out;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_length    <= KEY_W'(2);
      cfg.column_order  <= '0;
      cfg.start_size    <= CHUNK_ONE;
      cfg.swap_vertical <= 1'b0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_KEY_LENGTH:    cfg.key_length    <= pwdata[KEY_W-1:0];
        REG_COLUMN_ORDER:  cfg.column_order  <= pwdata;
        REG_START_SIZE:    cfg.start_size    <= pwdata[1:0];
        REG_SWAP_VERTICAL: cfg.swap_vertical <= pwdata[0];
        default:           cfg.swap_vertical <= cfg.swap_vertical;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KEY_LENGTH:    prdata = 64'(cfg.key_length);
      REG_COLUMN_ORDER:  prdata = cfg.column_order;
      REG_START_SIZE:    prdata = 64'(cfg.start_size);
      REG_SWAP_VERTICAL: prdata = 64'(cfg.swap_vertical);
      default:           prdata = '0;
    endcase
  end

  amsco_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (q_in)
  );

  amsco_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .word_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .word_out (q_out)
  );

  amsco_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_word   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// File: rtl/amsco_front.sv
// ----------------------------------------------------------------------------
// Amsco front end
// Accepts ciphertext words, assigns buffer slots and flags dropped bytes.
// ----------------------------------------------------------------------------
module amsco_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] cipher_byte
  input  logic                  s_tlast,
  input  logic                  q_full,
  output logic                  q_push,
  output amsco_pkg::queue_word_t q_word
);
  import amsco_pkg::*;

  logic [COUNT_W-1:0] text_count;
  logic               overflow_seen;
  logic               fits;

  assign fits     = (text_count < COUNT_W'(MAX_TEXT));
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_word.data  = s_tdata;
    q_word.addr  = text_count[TEXT_AW-1:0];
    q_word.store = fits;
    q_word.last  = s_tlast;
    q_word.count = fits ? (text_count + COUNT_W'(1)) : text_count;
    q_word.ovf   = overflow_seen || !fits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (q_push) begin
      if (s_tlast) begin
        text_count    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        text_count    <= q_word.count;
        overflow_seen <= q_word.ovf;
      end
    end
  end

endmodule

// File: rtl/amsco_queue.sv
// ----------------------------------------------------------------------------
// Amsco word queue
// Short FIFO that decouples the front end from the decrypt engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module amsco_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  amsco_pkg::queue_word_t word_in,
  output logic                   full,
  input  logic                   pop,
  output logic                   valid,
  output amsco_pkg::queue_word_t word_out
);
  import amsco_pkg::*;

  queue_word_t         slots [QUEUE_DEPTH];
  logic [QAW-1:0]      wr_ptr;
  logic [QAW-1:0]      rd_ptr;
  logic [QCOUNT_W-1:0] fill;

  assign full     = (fill == QCOUNT_W'(QUEUE_DEPTH));
  assign valid    = (fill != '0);
  assign word_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QCOUNT_W'(1);
        2'b01:   fill <= fill - QCOUNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, fill <= QCOUNT_W'(QUEUE_DEPTH), "queue fill beyond depth")
  `ASSERT_IMPLIES(a_pop_nonempty, pop, fill != '0, "pop from an empty queue")

endmodule

// File: rtl/amsco_back.sv
// ----------------------------------------------------------------------------
// Amsco decrypt engine
// Buffers ciphertext, sizes and places the columns, and reads out plaintext.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module amsco_back (
  input  logic                   clk,
  input  logic                   rst,
  input  amsco_pkg::cfg_t        cfg,
  input  logic                   q_valid,
  input  amsco_pkg::queue_word_t q_word,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // [7:0] plain_byte
  output logic                   m_tlast,
  output logic                   m_tuser    // [0] overflow
);
  import amsco_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [7:0]         text_store [MAX_TEXT];
  logic [COUNT_W-1:0] column_length [MAX_COLUMNS];
  logic [BASE_W-1:0]  column_base [MAX_COLUMNS];
  logic [COUNT_W-1:0] column_taken [MAX_COLUMNS];

  logic [COUNT_W-1:0] run_count;
  logic               run_ovf;
  logic [COUNT_W-1:0] idx;
  logic [1:0]         chunk;
  logic [COL_W-1:0]   col;
  logic [KEY_W-1:0]   bi;
  logic [BASE_W-1:0]  total;
  logic [COUNT_W-1:0] n;
  logic               half;
  logic [7:0]         mem_q;
  logic               addr_ok;

  logic               out_valid;
  logic [7:0]         out_data;
  logic               out_last;
  logic               out_ovf;

  logic [KEY_W-1:0]   key_k;
  logic [1:0]         start_chunk;
  deal_t              adv;
  logic [COUNT_W-1:0] left;
  logic [1:0]         take;
  logic [ENTRY_W-1:0] order_col;
  logic               order_ok;
  logic [BASE_W-1:0]  rd_addr;
  logic               chunk_end;
  logic               out_free;

  logic start_run, size_step, size_done, base_step, base_done, rd_issue, out_load;

  always_comb begin
    if (cfg.key_length < KEY_W'(2)) begin
      key_k = KEY_W'(2);
    end else if (cfg.key_length > KEY_W'(MAX_COLUMNS)) begin
      key_k = KEY_W'(MAX_COLUMNS);
    end else begin
      key_k = cfg.key_length;
    end
  end

  assign start_chunk = (cfg.start_size == CHUNK_TWO) ? CHUNK_TWO : CHUNK_ONE;
  assign adv         = deal_advance(chunk, col, key_k, cfg.swap_vertical);
  assign left        = run_count - idx;
  assign take        = (COUNT_W'(chunk) < left) ? chunk : left[1:0];
  assign order_col   = cfg.column_order[ENTRY_W*bi[COL_W-1:0] +: ENTRY_W];
  assign order_ok    = (KEY_W'(order_col) < key_k);
  assign rd_addr     = column_base[col] + BASE_W'(column_taken[col]);
  assign chunk_end   = (chunk == CHUNK_ONE) || half || (n + COUNT_W'(1) == run_count);
  assign out_free    = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    start_run  = 1'b0;
    size_step  = 1'b0;
    size_done  = 1'b0;
    base_step  = 1'b0;
    base_done  = 1'b0;
    rd_issue   = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_LOAD: begin
        q_pop = q_valid;
        if (q_valid && q_word.last) begin
          start_run  = 1'b1;
          state_next = B_SIZE;
        end
      end
      B_SIZE: begin
        if (idx < run_count) begin
          size_step = 1'b1;
        end else begin
          size_done  = 1'b1;
          state_next = B_BASE;
        end
      end
      B_BASE: begin
        if (bi < key_k) begin
          base_step = 1'b1;
        end else begin
          base_done  = 1'b1;
          state_next = B_ADDR;
        end
      end
      B_ADDR: begin
        rd_issue   = 1'b1;
        state_next = B_DATA;
      end
      B_DATA: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = (n == run_count) ? B_LOAD : B_ADDR;
        end
      end
      default: begin
        state_next = B_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_word.store) begin
      text_store[q_word.addr] <= q_word.data;
    end
    if (rd_issue) begin
      mem_q   <= text_store[rd_addr[TEXT_AW-1:0]];
      addr_ok <= (rd_addr < BASE_W'(run_count));
    end
  end

  always_ff @(posedge clk) begin
    if (start_run) begin
      run_count <= q_word.count;
      run_ovf   <= q_word.ovf;
      idx       <= '0;
      chunk     <= start_chunk;
      col       <= '0;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        column_length[c] <= '0;
        column_base[c]   <= '0;
        column_taken[c]  <= '0;
      end
    end
    if (size_step) begin
      column_length[col] <= column_length[col] + COUNT_W'(take);
      idx                <= idx + COUNT_W'(chunk);
      chunk              <= adv.chunk;
      col                <= adv.col;
    end
    if (size_done) begin
      bi    <= '0;
      total <= '0;
    end
    if (base_step) begin
      if (order_ok) begin
        column_base[order_col[COL_W-1:0]] <= total;
        total <= total + BASE_W'(column_length[order_col[COL_W-1:0]]);
      end
      bi <= bi + KEY_W'(1);
    end
    if (base_done) begin
      chunk <= start_chunk;
      col   <= '0;
      n     <= '0;
      half  <= 1'b0;
    end
    if (rd_issue) begin
      column_taken[col] <= column_taken[col] + COUNT_W'(1);
      n                 <= n + COUNT_W'(1);
      if (chunk_end) begin
        half  <= 1'b0;
        chunk <= adv.chunk;
        col   <= adv.col;
      end else begin
        half <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= addr_ok ? mem_q : 8'd0;
      out_last <= (n == run_count);
      out_ovf  <= run_ovf;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;
  assign m_tuser  = out_ovf;

  `ASSERT_IMPLIES(a_n_bound, state == B_ADDR || state == B_DATA, n <= run_count,
                  "readout ran past the buffered count")
  `ASSERT_NEXT(a_run_start, start_run, state == B_SIZE && idx == '0,
               "run did not start with column sizing")

endmodule

// File: bench/amsco_transposition_decrypt_top_tb.sv
// ----------------------------------------------------------------------------
// Amsco transposition decrypt testbench
// Loads ciphertext messages over the input stream under a series of register
// settings, predicts the plaintext of each message and checks every output
// word in order, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module amsco_transposition_decrypt_top_tb;
  import amsco_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_WORDS = 210;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } plain_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] cipher_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] plain_byte
  logic        m_tlast;
  logic        m_tuser;        // [0] overflow

  amsco_transposition_decrypt_top DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  cipher_word_t cipher_q[$];
  plain_word_t  plain_q[$];
  cipher_word_t next_word;
  plain_word_t  want;

  int words_queued = 0;
  int words_taken = 0;
  int mismatches = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int send_wait = 0;
  int recv_stall = 0;
  int hold_left = 0;
  bit steady = 1'b0;

  logic [7:0]  cipher_mem [MAX_TEXT];
  int          held_count = 0;
  logic        held_ovf = 1'b0;
  logic [4:0]  key_len_r = 5'd2;
  logic [63:0] order_r = '0;
  logic [1:0]  start_r = 2'd1;
  logic        swap_r = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void next_chunk(inout int chunk, inout int col, input int k);
    chunk = (chunk == 2) ? 1 : 2;
    col++;
    if (col >= k) begin
      col = 0;
    end
    if (col == 0 && swap_r && (k % 2) == 0) begin
      chunk = (chunk == 2) ? 1 : 2;
    end
  endfunction

  // Stores one ciphertext word; on the last word of a message, works out the
  // whole plaintext and appends it to plain_q.
  function automatic void take_cipher_word(input logic [7:0] b, input logic last);
    int k, count, idx, take, total, c, n, j, addr, chunk, col;
    int lens [MAX_COLUMNS];
    int bases [MAX_COLUMNS];
    int taken [MAX_COLUMNS];
    plain_word_t p;
    if (held_count < MAX_TEXT) begin
      cipher_mem[held_count] = b;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (!last) begin
      return;
    end
    k = (key_len_r < 2) ? 2 : (key_len_r > MAX_COLUMNS) ? MAX_COLUMNS : int'(key_len_r);
    count = held_count;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      lens[i] = 0;
      bases[i] = 0;
      taken[i] = 0;
    end
    chunk = (start_r == 2'd2) ? 2 : 1;
    col = 0;
    idx = 0;
    while (idx < count) begin
      take = (chunk < count - idx) ? chunk : count - idx;
      lens[col] += take;
      idx += chunk;
      next_chunk(chunk, col, k);
    end
    total = 0;
    for (int i = 0; i < k; i++) begin
      c = int'(order_r[4*i +: 4]);
      if (c < k) begin
        bases[c] = total;
        total += lens[c];
      end
    end
    chunk = (start_r == 2'd2) ? 2 : 1;
    col = 0;
    n = 0;
    while (n < count) begin
      for (j = 0; j < chunk && n < count; j++) begin
        addr = bases[col] + taken[col];
        p.data = (addr < count) ? cipher_mem[addr] : 8'h00;
        p.last = (n + 1 == count);
        p.ovf = held_ovf;
        plain_q.insert(plain_q.size(), p);
        taken[col]++;
        n++;
      end
      next_chunk(chunk, col, k);
    end
    held_count = 0;
    held_ovf = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait = 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        send_wait = steady ? 0 : $urandom_range(0, 4);
      end
      if (send_wait != 0 || cipher_q.size() == 0) begin
        s_tvalid <= 1'b0;
        if (send_wait != 0) begin
          send_wait--;
        end
      end else begin
        next_word = cipher_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= next_word.data;
        s_tlast <= next_word.last;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      words_taken++;
      take_cipher_word(s_tdata, s_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
      hold_left = 0;
    end else begin
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (m_tvalid && m_tready) begin
        recv_stall = steady ? 0 : $urandom_range(0, 4);
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (plain_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: data %h last %b overflow %b", m_tdata, m_tlast, m_tuser);
        end
      end else begin
        want = plain_q.pop_front();
        if (m_tdata !== want.data || m_tlast !== want.last || m_tuser !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected data %h last %b overflow %b, got data %h last %b overflow %b",
                     want.data, want.last, want.ovf, m_tdata, m_tlast, m_tuser);
          end
        end
      end
    end
  end

  task automatic queue_word(input logic [7:0] b, input logic last);
    cipher_word_t w;
    w.data = b;
    w.last = last;
    cipher_q.insert(cipher_q.size(), w);
    words_queued++;
  endtask

  task automatic queue_message(input int len);
    for (int i = 0; i < len; i++) begin
      queue_word(8'($urandom), i == len - 1);
    end
  endtask

  task automatic wait_idle();
    while (words_taken != words_queued || plain_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    logic [63:0] want_reg;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KEY_LENGTH: begin
        key_len_r = val[4:0];
        want_reg = 64'(val[4:0]);
      end
      REG_COLUMN_ORDER: begin
        order_r = val;
        want_reg = val;
      end
      REG_START_SIZE: begin
        start_r = val[1:0];
        want_reg = 64'(val[1:0]);
      end
      REG_SWAP_VERTICAL: begin
        swap_r = val[0];
        want_reg = 64'(val[0]);
      end
      default: begin
        want_reg = '0;
      end
    endcase
    #1;
    if (prdata !== want_reg) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("register read-back: expected %h, got %h", want_reg, prdata);
      end
    end
  endtask

  task automatic configure(input logic [4:0] k, input logic [63:0] order,
                           input logic [1:0] start, input logic swap);
    wait_idle();
    write_reg(REG_KEY_LENGTH, 64'(k));
    write_reg(REG_COLUMN_ORDER, order);
    write_reg(REG_START_SIZE, 64'(start));
    write_reg(REG_SWAP_VERTICAL, 64'(swap));
    steady = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [63:0] shuffled_order(input int k);
    logic [3:0]  e [16];
    logic [3:0]  t;
    logic [63:0] r;
    int          p;
    for (int i = 0; i < 16; i++) begin
      e[i] = (i < k) ? 4'(i) : 4'($urandom_range(0, 15));
    end
    for (int i = k - 1; i > 0; i--) begin
      p = $urandom_range(0, i);
      t = e[i];
      e[i] = e[p];
      e[p] = t;
    end
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = e[i];
    end
    return r;
  endfunction

  initial begin
    int rand_words, k, len, msgs;
    logic [63:0] order;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Defaults: a zero order names column 0 twice and leaves column 1 unnamed.
    queue_word(8'h00, 1'b1);
    queue_word(8'hFF, 1'b0);
    queue_word(8'h80, 1'b0);
    queue_word(8'h01, 1'b0);
    queue_word(8'h7F, 1'b0);
    queue_word(8'h55, 1'b1);
    configure(5'd16, 64'h0123_4567_89AB_CDEF, 2'd2, 1'b1);
    queue_message(12);
    configure(5'd0, 64'h0000_0000_0000_0010, 2'd0, 1'b1);
    queue_message(3);
    configure(5'd31, 64'hFEDC_BA98_7654_3210, 2'd3, 1'b0);
    queue_message(2);
    configure(5'd3, 64'hFFFF_FFFF_FFFF_2F01, 2'd1, 1'b1);
    queue_message(2);

    // Long receiver hold-off over an overflowing message and a follow-up.
    configure(5'd5, shuffled_order(5), 2'd2, 1'b0);
    holds_asked++;
    queue_message(MAX_TEXT + 2);
    queue_message(20);
    rand_words = words_queued;

    while (rand_words < RANDOM_WORDS) begin
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
      case ($urandom_range(0, 7))
        0: order = {$urandom, $urandom};
        1: order = shuffled_order(16) & {16{4'($urandom_range(0, 15))}};
        default: order = shuffled_order((k < 2) ? 2 : (k > 16) ? 16 : k);
      endcase
      configure(5'(k), order, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      msgs = $urandom_range(1, 3);
      for (int m = 0; m < msgs; m++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, MAX_TEXT) : $urandom_range(1, 24);
        queue_message(len);
        rand_words += len;
      end
    end

    wait_idle();
    if (mismatches == 0 && plain_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
